// ----- hdl/dfq_pkg.sv -----
// dfq_pkg: shared types and codes for the dedup FIFO with keyed removal.
// No dependencies; imported by dfq_ram, dfq_seq and the top level.
package dfq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CNT_OUT_W     = 5;

   // operation codes (req_tuser)
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_DUP   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [31:0] unique_id;
      logic [31:0] session_id;
   } entry_type;

   typedef struct packed {
      logic                 ok;
      logic [1:0]           status;
      logic [31:0]          head_session_id;
      logic [31:0]          head_unique_id;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

endpackage

// ----- hdl/dfq_ram.sv -----
// dfq_ram: entry store, one write port and one read port, registered read data.
// Depends on dfq_pkg (entry_type).
module dfq_ram #(
   parameter int QUEUE_DEPTH = dfq_pkg::DEPTH_DEFAULT,
   parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output dfq_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  dfq_pkg::entry_type  wr_data
);
   import dfq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dfq_seq.sv -----
// dfq_seq: operation sequencer - search, append, pop and gap-closing shift.
// Depends on dfq_pkg and drives one dfq_ram instance.
module dfq_seq #(
   parameter int QUEUE_DEPTH = dfq_pkg::DEPTH_DEFAULT,
   parameter int IDX_W       = $clog2(QUEUE_DEPTH),
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   // command
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  logic [1:0]         cmd_op,
   input  logic [31:0]        cmd_session_id,
   input  logic [31:0]        cmd_unique_id,
   // result
   output logic               res_valid,
   input  logic               res_take,
   output dfq_pkg::rsp_type   res,
   // store
   output logic               rd_en,
   output logic [IDX_W-1:0]   rd_addr,
   input  dfq_pkg::entry_type rd_data,
   output logic               wr_en,
   output logic [IDX_W-1:0]   wr_addr,
   output dfq_pkg::entry_type wr_data
);
   import dfq_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SEARCH  = 3'd1;
   localparam logic [2:0] S_POP_RD  = 3'd2;
   localparam logic [2:0] S_POP_CAP = 3'd3;
   localparam logic [2:0] S_SHIFT   = 3'd4;
   localparam logic [2:0] S_FINISH  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [31:0]      sid_ff, sid_in;
   logic [31:0]      uid_ff, uid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             inflt_ff, inflt_in;
   logic [IDX_W-1:0] inflt_idx_ff, inflt_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             ok_ff, ok_in;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      hs_ff, hs_in;
   logic [31:0]      hu_ff, hu_in;

   logic             hit;
   logic             more;
   logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

   assign hit  = inflt_ff && (rd_data.session_id == sid_ff);
   assign more = rd_idx_ff < count_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sid_in       = sid_ff;
      uid_in       = uid_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      inflt_in     = inflt_ff;
      inflt_idx_in = inflt_idx_ff;
      wr_idx_in    = wr_idx_ff;
      ok_in        = ok_ff;
      status_in    = status_ff;
      hs_in        = hs_ff;
      hu_in        = hu_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = wr_idx_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               op_in     = cmd_op;
               sid_in    = cmd_session_id;
               uid_in    = cmd_unique_id;
               rd_idx_in = '0;
               inflt_in  = 1'b0;
               ok_in     = 1'b0;
               status_in = ST_DONE;
               hs_in     = '0;
               hu_in     = '0;
               if (cmd_op != OP_ADD && count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_FINISH;
               end else if (cmd_op == OP_POP) begin
                  state_in = S_POP_RD;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               case (op_ff)
                  OP_ADD: begin
                     status_in = ST_DUP;
                     state_in  = S_FINISH;
                  end
                  OP_REMOVE: begin
                     ok_in     = 1'b1;
                     wr_idx_in = inflt_idx_ff;
                     rd_idx_in = {{(CNT_W-IDX_W){1'b0}}, inflt_idx_ff} + CNT_W'(1);
                     inflt_in  = 1'b0;
                     state_in  = S_SHIFT;
                  end
                  default: begin
                     ok_in    = 1'b1;
                     state_in = S_FINISH;
                  end
               endcase
            end else if (more) begin
               rd_en        = 1'b1;
               inflt_in     = 1'b1;
               inflt_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
            end else begin
               // whole queue scanned, no match
               inflt_in = 1'b0;
               state_in = S_FINISH;
               case (op_ff)
                  OP_ADD: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = '{unique_id: uid_ff, session_id: sid_ff};
                        count_in = count_ff + CNT_W'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  OP_REMOVE: ok_in = 1'b1;
                  default:   ok_in = 1'b0;
               endcase
            end
         end
         S_POP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_POP_CAP;
         end
         S_POP_CAP: begin
            hs_in     = rd_data.session_id;
            hu_in     = rd_data.unique_id;
            ok_in     = 1'b1;
            inflt_in  = 1'b0;
            wr_idx_in = '0;
            rd_idx_in = CNT_W'(1);
            state_in  = S_SHIFT;
         end
         S_SHIFT: begin
            // read slot k+1 while slot k-1 takes the previous read
            if (inflt_ff) begin
               wr_en     = 1'b1;
               wr_idx_in = wr_idx_ff + IDX_W'(1);
            end
            if (more) begin
               rd_en     = 1'b1;
               inflt_in  = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end else begin
               inflt_in = 1'b0;
               if (!inflt_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         inflt_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         inflt_ff <= inflt_in;
      end
      op_ff        <= op_in;
      sid_ff       <= sid_in;
      uid_ff       <= uid_in;
      rd_idx_ff    <= rd_idx_in;
      inflt_idx_ff <= inflt_idx_in;
      wr_idx_ff    <= wr_idx_in;
      ok_ff        <= ok_in;
      status_ff    <= status_in;
      hs_ff        <= hs_in;
      hu_ff        <= hu_in;
   end

   assign cnt_ext   = {{CNT_OUT_W{1'b0}}, count_ff};
   assign cmd_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FINISH);

   always_comb begin
      res.ok              = ok_ff;
      res.status          = status_ff;
      res.head_session_id = hs_ff;
      res.head_unique_id  = hu_ff;
      res.entry_count     = cnt_ext[CNT_OUT_W-1:0];
   end

endmodule

// ----- hdl/dedup_fifo_with_keyed_removal.sv -----
// dedup_fifo_with_keyed_removal: top level, stream ports and result register.
// Depends on dfq_pkg, dfq_ram and dfq_seq.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | req_tvalid/tready  | tuser: op; tdata: session id, unique id
//  rsp     | out | rsp_tvalid/tready  | tuser: ok, status; tdata: head ids, count
//
//  One transaction in, exactly one out, in order. An add or query scans the
//  store at one slot per cycle. A remove that hits, or a pop, then closes the
//  gap at one slot per cycle (read port bound). Empty-queue rejects skip the scan.
//  Reset (synchronous) empties the queue; store contents are not cleared.
//  A result waits in the output register under rsp_tready low; the next request
//  is taken meanwhile and its result holds in the sequencer until the slot frees.
module dedup_fifo_with_keyed_removal #(
   parameter int QUEUE_DEPTH = dfq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic [63:0] req_tdata,   // [31:0] user_session_id, [63:32] user_unique_id
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [0] ok, [2:1] status
   output logic [71:0] rsp_tdata    // [31:0] head_session_id, [63:32] head_unique_id,
                                    // [68:64] entry_count, [71:69] zero
);
   import dfq_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   entry_type        rd_data, wr_data;

   logic    res_valid, res_take;
   rsp_type res;

   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   dfq_ram #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   dfq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (req_tvalid),
      .cmd_ready      (req_tready),
      .cmd_op         (req_tuser),
      .cmd_session_id (req_tdata[31:0]),
      .cmd_unique_id  (req_tdata[63:32]),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res            (res),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data)
   );

   // output register: loads when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_vld_ff || rsp_tready);

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (res_take) begin
         rsp_vld_in = 1'b1;
         rsp_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.ok};
   assign rsp_tdata  = {3'b000, rsp_ff.entry_count, rsp_ff.head_unique_id,
                        rsp_ff.head_session_id};

endmodule
